### design/ogru_pkg.sv
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared constants, types and arithmetic helpers of the ray update unit.
// ----------------------------------------------------------------------------
package ogru_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int CELL_BITS  = 16;

    localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(GRID_DEPTH);
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);

    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = 16;
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int WALK_BITS  = 17;
    localparam int SCAN_BITS  = 32;
    localparam int DELTA_BITS = 16;
    localparam int VALUE_BITS = 16;

    localparam int SUM_W = ((CELL_BITS > DELTA_BITS) ? CELL_BITS : DELTA_BITS) + 1;
    localparam int RV_W  = (CELL_BITS > VALUE_BITS) ? CELL_BITS : VALUE_BITS;

    localparam logic signed [SUM_W-1:0] CELL_HI =
        SUM_W'((64'sd1 <<< (CELL_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] CELL_LO =
        SUM_W'(-(64'sd1 <<< (CELL_BITS - 1)));

    // register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FREE_DELTA  = 2'd2;
    localparam logic [1:0] REG_HIT_DELTA   = 2'd3;

    localparam logic [8:0]  RST_GRID_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;
    localparam logic [15:0] RST_FREE_DELTA  = 16'hFF9A;  // -0.4 in Q8.8
    localparam logic [15:0] RST_HIT_DELTA   = 16'h00DA;  // 0.85 in Q8.8

    // request kinds
    localparam logic REQ_RAY  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic [8:0]               grid_width;
        logic [8:0]               grid_height;
        logic signed [DELTA_BITS-1:0] free_delta;
        logic signed [DELTA_BITS-1:0] hit_delta;
    } cfg_t;

    typedef struct packed {
        logic                         req_type;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         scan_end;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        logic [WALK_BITS-1:0]         cells_walked;
        logic [SCAN_BITS-1:0]         scans_done;
    } result_t;

    typedef struct packed {
        logic load;      // latch a new item and set up the line walk
        logic walk;      // visit the current cell and advance
        logic rd_issue;  // read the cell at the start point
        logic out_load;  // fill the output register
        logic clear;     // write zero at the clear counter
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic at_end;
    } status_t;

    function automatic logic signed [CELL_BITS-1:0] cell_sat_add(
        logic signed [CELL_BITS-1:0]  c,
        logic signed [DELTA_BITS-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(c) + SUM_W'(d);
        if (s > CELL_HI) begin
            s = CELL_HI;
        end else if (s < CELL_LO) begin
            s = CELL_LO;
        end
        return CELL_BITS'(s);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] value_sat(
        logic signed [CELL_BITS-1:0] c
    );
        logic signed [RV_W-1:0] w;
        w = RV_W'(c);
        if (w > RV_W'(32767)) begin
            w = RV_W'(32767);
        end else if (w < RV_W'(-32768)) begin
            w = RV_W'(-32768);
        end
        return VALUE_BITS'(w);
    endfunction

endpackage

### design/occupancy_grid_ray_update_unit.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_unit
// Log-odds occupancy grid, updated one Bresenham ray per ray word; read words return one cell.
// ----------------------------------------------------------------------------
// After reset the unit clears the grid RAM, one cell per cycle, all
// MAX_WIDTH * MAX_HEIGHT cells, with s_tready low; register writes are taken
// throughout. In a ray update the walk visits one cell a cycle, its
// read-modify-write spread over the grid RAM's read port and write port.
// One word is worked on at a time; a new word is accepted while the previous
// result still waits in the output register.
module occupancy_grid_ray_update_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // scan_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // read_value, cells_walked, scans_done, zero pad

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ogru_pkg::*;

    cfg_t    cfg;
    item_t   item;
    cmd_t    cmd;
    status_t status;
    result_t result;

    assign item.req_type = s_tuser;
    assign item.start_x  = s_tdata[15:0];
    assign item.start_y  = s_tdata[31:16];
    assign item.end_x    = s_tdata[47:32];
    assign item.end_y    = s_tdata[63:48];
    assign item.scan_end = s_tlast;

    assign m_tdata = {7'd0, result.scans_done, result.cells_walked, result.read_value};

    ogru_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ogru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ogru_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

### design/ogru_ram.sv
// ----------------------------------------------------------------------------
// ogru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ogru_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ogru_cfg.sv
// ----------------------------------------------------------------------------
// ogru_cfg
// APB register bank: grid size and the two log-odds increments.
// ----------------------------------------------------------------------------
module ogru_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ogru_pkg::cfg_t cfg
);
    import ogru_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width  <= RST_GRID_WIDTH;
            cfg_reg.grid_height <= RST_GRID_HEIGHT;
            cfg_reg.free_delta  <= RST_FREE_DELTA;
            cfg_reg.hit_delta   <= RST_HIT_DELTA;
        end else if (wr_en) begin
            case (idx)
                REG_GRID_WIDTH:  cfg_reg.grid_width  <= pwdata[8:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height <= pwdata[8:0];
                REG_FREE_DELTA:  cfg_reg.free_delta  <= pwdata[15:0];
                REG_HIT_DELTA:   cfg_reg.hit_delta   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GRID_WIDTH:  prdata = {23'd0, cfg_reg.grid_width};
            REG_GRID_HEIGHT: prdata = {23'd0, cfg_reg.grid_height};
            REG_FREE_DELTA:  prdata = {16'd0, cfg_reg.free_delta};
            REG_HIT_DELTA:   prdata = {16'd0, cfg_reg.hit_delta};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/ogru_datapath.sv
// ----------------------------------------------------------------------------
// ogru_datapath
// Line stepper, grid RAM read-modify-write pipe, scan counter, result register.
// ----------------------------------------------------------------------------
module ogru_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  ogru_pkg::cfg_t    cfg,
    input  ogru_pkg::item_t   item,
    input  ogru_pkg::cmd_t    cmd,
    output ogru_pkg::status_t status,
    output ogru_pkg::result_t result
);
    import ogru_pkg::*;

    // current item
    logic                         req_reg;
    logic                         scan_end_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, x1_reg, y1_reg;
    logic signed [DIST_BITS-1:0]  dx_reg, dy_reg;
    logic                         sx_neg_reg, sy_neg_reg;
    logic signed [ERR_BITS-1:0]   err_reg;
    logic [WALK_BITS-1:0]         walked_reg;

    // one cell in flight between RAM read and write
    logic                         s1_valid_reg;
    logic                         s1_inside_reg;
    logic                         s1_end_reg;
    logic [ADDR_BITS-1:0]         s1_addr_reg;

    logic [ADDR_BITS-1:0]         clr_cnt_reg;
    logic [SCAN_BITS-1:0]         scan_count_reg;
    result_t                      result_reg;

    // set-up values
    logic signed [DIST_BITS-1:0]  ldx, ldy;
    logic                         x_gt, y_gt;

    // stepping
    logic signed [ERR_BITS:0]     e2;
    logic                         x_step, y_step;
    logic signed [ERR_BITS-1:0]   err_next;
    logic                         at_end;

    // bounds and address
    logic [DIM_BITS-1:0]          eff_w, eff_h;
    logic                         cur_inside;
    logic [ADDR_BITS-1:0]         cur_addr;

    // RAM
    logic                         ram_we, ram_re;
    logic [ADDR_BITS-1:0]         ram_waddr;
    logic [CELL_BITS-1:0]         ram_wdata, ram_rdata;
    logic signed [CELL_BITS-1:0]  upd_value;
    logic [SCAN_BITS-1:0]         scan_next;

    assign x_gt = item.end_x > item.start_x;
    assign y_gt = item.end_y > item.start_y;
    assign ldx  = x_gt ? DIST_BITS'(item.end_x) - DIST_BITS'(item.start_x)
                       : DIST_BITS'(item.start_x) - DIST_BITS'(item.end_x);
    // dy is kept negative, as in the classic all-octant form
    assign ldy  = y_gt ? DIST_BITS'(item.start_y) - DIST_BITS'(item.end_y)
                       : DIST_BITS'(item.end_y) - DIST_BITS'(item.start_y);

    assign e2       = (ERR_BITS + 1)'(err_reg) <<< 1;
    assign x_step   = e2 >= (ERR_BITS + 1)'(dy_reg);
    assign y_step   = e2 <= (ERR_BITS + 1)'(dx_reg);
    assign err_next = err_reg + (x_step ? ERR_BITS'(dy_reg) : '0)
                              + (y_step ? ERR_BITS'(dx_reg) : '0);
    assign at_end   = (x_reg == x1_reg) && (y_reg == y1_reg);

    assign eff_w = ({7'd0, cfg.grid_width} > DIM_BITS'(MAX_WIDTH))
                 ? DIM_BITS'(MAX_WIDTH) : {7'd0, cfg.grid_width};
    assign eff_h = ({7'd0, cfg.grid_height} > DIM_BITS'(MAX_HEIGHT))
                 ? DIM_BITS'(MAX_HEIGHT) : {7'd0, cfg.grid_height};
    assign cur_inside = !x_reg[COORD_BITS-1] && !y_reg[COORD_BITS-1]
                     && (DIM_BITS'(unsigned'(x_reg)) < eff_w)
                     && (DIM_BITS'(unsigned'(y_reg)) < eff_h);
    assign cur_addr = ADDR_BITS'(y_reg[Y_BITS-1:0] * MAX_WIDTH)
                    + ADDR_BITS'(x_reg[X_BITS-1:0]);

    assign ram_re    = (cmd.walk | cmd.rd_issue) & cur_inside;
    assign upd_value = cell_sat_add(ram_rdata,
                                    s1_end_reg ? cfg.hit_delta : cfg.free_delta);

    always_comb begin
        if (cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_valid_reg & s1_inside_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = upd_value;
        end
    end

    ogru_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg      <= item.req_type;
            scan_end_reg <= item.scan_end;
            x_reg        <= item.start_x;
            y_reg        <= item.start_y;
            x1_reg       <= item.end_x;
            y1_reg       <= item.end_y;
            dx_reg       <= ldx;
            dy_reg       <= ldy;
            sx_neg_reg   <= !x_gt;
            sy_neg_reg   <= !y_gt;
            err_reg      <= ERR_BITS'(ldx) + ERR_BITS'(ldy);
            walked_reg   <= '0;
        end else if (cmd.walk) begin
            walked_reg <= walked_reg + 1'b1;
            err_reg    <= err_next;
            if (x_step) begin
                x_reg <= sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
            end
            if (y_step) begin
                y_reg <= sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
            end
        end
        if (cmd.walk | cmd.rd_issue) begin
            s1_inside_reg <= cur_inside;
            s1_end_reg    <= at_end;
            s1_addr_reg   <= cur_addr;
        end
    end

    assign scan_next = scan_count_reg + SCAN_BITS'(scan_end_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
            scan_count_reg <= '0;
        end else begin
            s1_valid_reg <= cmd.walk;
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.out_load && req_reg == REQ_RAY) begin
                scan_count_reg <= scan_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (req_reg == REQ_READ) begin
                result_reg.read_value   <= s1_inside_reg ? value_sat(ram_rdata) : '0;
                result_reg.cells_walked <= '0;
                result_reg.scans_done   <= scan_count_reg;
            end else begin
                result_reg.read_value   <= '0;
                result_reg.cells_walked <= walked_reg;
                result_reg.scans_done   <= scan_next;
            end
        end
    end

    assign status.clr_last = clr_cnt_reg == ADDR_BITS'(GRID_DEPTH - 1);
    assign status.at_end   = at_end;
    assign result          = result_reg;

endmodule

### design/ogru_ctrl.sv
// ----------------------------------------------------------------------------
// ogru_ctrl
// Sequencer: grid clear after reset, per-item walk or read, output handshake.
// ----------------------------------------------------------------------------
module ogru_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              req_type,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ogru_pkg::status_t status,
    output ogru_pkg::cmd_t    cmd
);
    import ogru_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (req_type == REQ_READ) ? ST_READ : ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.at_end) begin
                    state_next = ST_FIN;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### design/ogru_checker.sv
// ----------------------------------------------------------------------------
// ogru_checker
// Port-level checks of the ray update unit, bound to the top level.
// ----------------------------------------------------------------------------
module ogru_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // reset puts the unit into the clear pass with no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("unit not quiet after reset");

    // one word in flight: accepting a word closes the input
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after a word was taken");

    // a fresh result only follows a busy phase
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work in progress");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind occupancy_grid_ray_update_unit ogru_checker u_ogru_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/occupancy_grid_ray_update_unit_tb.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_unit_tb
// Drives ray and cell-read words into the grid unit, keeps its own copy of the
// log-odds grid, walks each ray the same way, and compares every result word
// field by field. A short directed table comes first (extremes, saturation,
// out-of-range cells, register corners), then randomized phases under several
// register settings, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update_unit_tb;

    import ogru_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // start_x, start_y, end_x, end_y
    logic        s_tuser  = 1'b0;  // req_type
    logic        s_tlast  = 1'b0;  // scan_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // read_value, cells_walked, scans_done, zero pad
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    occupancy_grid_ray_update_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // grid and register copies used for prediction
    logic signed [CELL_BITS-1:0] grid_model [GRID_DEPTH];
    logic [SCAN_BITS-1:0]        scan_model;
    logic [8:0]                  width_model  = RST_GRID_WIDTH;
    logic [8:0]                  height_model = RST_GRID_HEIGHT;
    logic signed [15:0]          free_model   = RST_FREE_DELTA;
    logic signed [15:0]          hit_model    = RST_HIT_DELTA;

    result_t pending_results [$];
    int      fail_count = 0;

    typedef struct packed {
        bit       is_cfg;
        bit [1:0] reg_idx;
        int       reg_val;
        bit       req;
        int       sx;
        int       sy;
        int       ex;
        int       ey;
        bit       last;
        bit       typed;
        int       val;
        int       walked;
        int       scans;
    } step_row_t;

    localparam int N_STEPS = 35;
    step_row_t directed_steps [N_STEPS];

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #24000000;
        $display("occupancy_grid_ray_update_unit_tb: FAIL");
        $finish;
    end

    function automatic bit cell_in_grid(int x, int y);
        int w;
        int h;
        w = (width_model > 9'(MAX_WIDTH)) ? MAX_WIDTH : int'(width_model);
        h = (height_model > 9'(MAX_HEIGHT)) ? MAX_HEIGHT : int'(height_model);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    function automatic void bump_cell(int x, int y, int delta);
        int idx;
        int s;
        if (cell_in_grid(x, y)) begin
            idx = y * MAX_WIDTH + x;
            s = int'(grid_model[idx]) + delta;
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            grid_model[idx] = 16'(s);
        end
    endfunction

    // Bresenham walk over the grid copy; one result per word
    function automatic result_t apply_word(item_t w);
        result_t r;
        int x0, y0, x1, y1;
        int dx, dy, sx, sy, err, e2, x, y;
        int walked;
        bit done;
        r  = '0;
        x0 = w.start_x;
        y0 = w.start_y;
        x1 = w.end_x;
        y1 = w.end_y;
        if (w.req_type == REQ_READ) begin
            if (cell_in_grid(x0, y0)) r.read_value = grid_model[y0 * MAX_WIDTH + x0];
        end else begin
            dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
            sx  = (x1 > x0) ? 1 : -1;
            sy  = (y1 > y0) ? 1 : -1;
            err = dx + dy;
            x = x0;
            y = y0;
            walked = 0;
            done = 1'b0;
            while (!done) begin
                e2 = err * 2;
                walked++;
                if (x == x1 && y == y1) begin
                    bump_cell(x, y, hit_model);
                    done = 1'b1;
                end else begin
                    bump_cell(x, y, free_model);
                    if (e2 >= dy) begin
                        err += dy;
                        x += sx;
                    end
                    if (e2 <= dx) begin
                        err += dx;
                        y += sy;
                    end
                end
            end
            if (w.scan_end) scan_model++;
            r.cells_walked = 17'(walked);
        end
        r.scans_done = scan_model;
        return r;
    endfunction

    function automatic int clip_coord(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic send_word(item_t w, bit typed, result_t typed_res);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {w.end_y, w.end_x, w.start_y, w.start_x};
        s_tuser  <= w.req_type;
        s_tlast  <= w.scan_end;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = apply_word(w);
        pending_results = {pending_results, (typed ? typed_res : predicted)};
    endtask

    task automatic idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  width_model  = val[8:0];
            REG_GRID_HEIGHT: height_model = val[8:0];
            REG_FREE_DELTA:  free_model   = val[15:0];
            REG_HIT_DELTA:   hit_model    = val[15:0];
            default: ;
        endcase
    endtask

    // result sink: modes of always ready, coin flip, sparse, long stall
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 200);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom);
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (left < 5);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tdata[32:16] !== want.cells_walked) begin
                    $error("cells_walked: expected %0d, got %0d",
                           want.cells_walked, m_tdata[32:16]);
                    fail_count++;
                end
                if (m_tdata[64:33] !== want.scans_done) begin
                    $error("scans_done: expected %0d, got %0d",
                           want.scans_done, m_tdata[64:33]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        step_row_t row;
        item_t     w;
        result_t   want;
        int        gap, burst_left, kind, span;
        int        x0, y0, x1, y1;
        int        cfg_w, cfg_h, cfg_f, cfg_hit;

        foreach (grid_model[i]) grid_model[i] = '0;
        scan_model = '0;

        // typed expectations only where the value is obvious
        directed_steps = '{
            '{0, 0, 0, REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            '{0, 0, 0, REQ_RAY, 5, 5, 5, 5, 0, 1, 0, 1, 0},
            '{0, 0, 0, REQ_READ, 5, 5, 0, 0, 0, 1, 218, 0, 0},
            '{0, 0, 0, REQ_RAY, 0, 0, 10, 0, 1, 1, 0, 11, 1},
            '{0, 0, 0, REQ_READ, 0, 0, 0, 0, 0, 1, -102, 0, 1},
            '{0, 0, 0, REQ_READ, 10, 0, 0, 0, 0, 1, 218, 0, 1},
            '{0, 0, 0, REQ_RAY, 3, -5, 3, 5, 0, 1, 0, 11, 1},
            '{0, 0, 0, REQ_READ, -1, -1, 0, 0, 1, 1, 0, 0, 1},
            '{0, 0, 0, REQ_READ, 256, 0, 0, 0, 0, 1, 0, 0, 1},
            '{0, 0, 0, REQ_RAY, -32768, -32768, 32767, 32767, 0, 1, 0, 65536, 1},
            '{0, 0, 0, REQ_RAY, 32767, -32768, -32768, 32767, 1, 1, 0, 65536, 2},
            '{0, 0, 0, REQ_READ, 1, 1, -32768, 32767, 0, 0, 0, 0, 0},
            '{0, 0, 0, REQ_READ, 32767, 32767, 0, 0, 0, 1, 0, 0, 2},
            '{0, 0, 0, REQ_RAY, 255, 0, 0, 255, 0, 1, 0, 256, 2},
            '{0, 0, 0, REQ_RAY, 10, 10, 13, 40, 1, 0, 0, 0, 0},
            '{0, 0, 0, REQ_RAY, 40, 40, 20, 35, 0, 0, 0, 0, 0},
            '{1, REG_GRID_WIDTH, 511, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_GRID_HEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, REQ_RAY, 0, 0, 3, 3, 0, 1, 0, 4, 3},
            '{0, 0, 0, REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0, 3},
            '{1, REG_GRID_WIDTH, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_GRID_HEIGHT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, REQ_RAY, 1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_GRID_WIDTH, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_GRID_HEIGHT, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_FREE_DELTA, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, REG_HIT_DELTA, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, REQ_RAY, 100, 100, 100, 100, 0, 1, 0, 1, 3},
            '{0, 0, 0, REQ_RAY, 100, 100, 100, 100, 0, 1, 0, 1, 3},
            '{0, 0, 0, REQ_READ, 100, 100, 0, 0, 0, 1, 32767, 0, 3},
            '{0, 0, 0, REQ_RAY, 100, 100, 100, 101, 0, 1, 0, 2, 3},
            '{0, 0, 0, REQ_RAY, 100, 100, 100, 101, 0, 1, 0, 2, 3},
            '{0, 0, 0, REQ_READ, 100, 100, 0, 0, 0, 1, -32768, 0, 3},
            '{0, 0, 0, REQ_READ, 100, 101, 0, 0, 0, 0, 0, 0, 0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) begin
            row = directed_steps[i];
            if (row.is_cfg) begin
                wait_drain();
                apb_write(row.reg_idx, row.reg_val);
            end else begin
                w.req_type = row.req;
                w.start_x  = 16'(row.sx);
                w.start_y  = 16'(row.sy);
                w.end_x    = 16'(row.ex);
                w.end_y    = 16'(row.ey);
                w.scan_end = row.last;
                want.read_value   = 16'(row.val);
                want.cells_walked = 17'(row.walked);
                want.scans_done   = row.scans;
                send_word(w, row.typed, want);
                gap = $urandom_range(0, 2);
                if (gap > 0) idle_sender(gap);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            span = 300;
            case (phase)
                0: begin
                    cfg_w = 256; cfg_h = 256; cfg_f = -102; cfg_hit = 218;
                end
                1: begin
                    cfg_w = $urandom_range(1, 256); cfg_h = $urandom_range(1, 256);
                    cfg_f = -$urandom_range(1, 400); cfg_hit = $urandom_range(1, 600);
                end
                2: begin
                    // width beyond the maximum acts as 256; height may fall either side of it
                    cfg_w = $urandom_range(257, 511); cfg_h = $urandom_range(200, 511);
                    cfg_f = -32768; cfg_hit = 32767;
                end
                3: begin
                    cfg_w = 0; cfg_h = $urandom_range(0, 511);
                    cfg_f = $urandom; cfg_hit = $urandom;
                end
                4: begin
                    cfg_w = $urandom_range(0, 511); cfg_h = $urandom_range(0, 511);
                    cfg_f = $urandom; cfg_hit = $urandom;
                end
                default: begin
                    // tiny grid, big steps: drives both saturation rails
                    cfg_w = $urandom_range(1, 16); cfg_h = $urandom_range(1, 16);
                    cfg_f = -$urandom_range(8000, 32768); cfg_hit = $urandom_range(8000, 32767);
                    span = 24;
                end
            endcase
            wait_drain();
            apb_write(REG_GRID_WIDTH, cfg_w);
            apb_write(REG_GRID_HEIGHT, cfg_h);
            apb_write(REG_FREE_DELTA, cfg_f);
            apb_write(REG_HIT_DELTA, cfg_hit);

            burst_left = 0;
            want = '0;
            for (int n = 0; n < 320; n++) begin
                kind = $urandom_range(0, 99);
                w = '0;
                if (kind < 30) begin
                    w.req_type = REQ_READ;
                    if (kind < 20) begin
                        w.start_x = 16'($urandom_range(0, span + 16) - 8);
                        w.start_y = 16'($urandom_range(0, span + 16) - 8);
                    end else begin
                        w.start_x = 16'($urandom);
                        w.start_y = 16'($urandom);
                    end
                    w.end_x    = 16'($urandom);
                    w.end_y    = 16'($urandom);
                    w.scan_end = 1'($urandom);
                end else begin
                    w.req_type = REQ_RAY;
                    x0 = $urandom_range(0, span + 16) - 8;
                    y0 = $urandom_range(0, span + 16) - 8;
                    if (kind < 80) begin
                        x1 = x0 + $urandom_range(0, 48) - 24;
                        y1 = y0 + $urandom_range(0, 48) - 24;
                    end else if (kind < 94) begin
                        x1 = $urandom_range(0, span + 80) - 40;
                        y1 = $urandom_range(0, span + 80) - 40;
                    end else begin
                        // short ray far out, exercises the high coordinate bits
                        x0 = $urandom_range(0, 65535) - 32768;
                        y0 = $urandom_range(0, 65535) - 32768;
                        x1 = clip_coord(x0 + $urandom_range(0, 16) - 8);
                        y1 = clip_coord(y0 + $urandom_range(0, 16) - 8);
                    end
                    w.start_x  = 16'(x0);
                    w.start_y  = 16'(y0);
                    w.end_x    = 16'(x1);
                    w.end_y    = 16'(y1);
                    w.scan_end = ($urandom_range(0, 7) == 0);
                end
                send_word(w, 1'b0, want);

                if ($urandom_range(0, 99) == 0) begin
                    wait_drain();
                end else begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        if (gap > 0) idle_sender(gap);
                    end
                    burst_left--;
                end
            end
        end

        wait_drain();
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("occupancy_grid_ray_update_unit_tb: PASS");
        end else begin
            $display("occupancy_grid_ray_update_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
